// ===== hdl/gamepad_record_mapper_macros.svh =====
// Assertion macros for the gamepad record mapper checker.
// Depends on nothing; the asserting module supplies aclk and aresetn.
`ifndef GAMEPAD_RECORD_MAPPER_MACROS_SVH
`define GAMEPAD_RECORD_MAPPER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define GMR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define GMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gmr_pkg.sv =====
// Shared types, constants and helper functions of the gamepad record mapper.
// No dependencies; imported by every module of the block.
package gmr_pkg;

    // Stream payload widths
    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 104;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_RECORD_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE   = 2'd1;

    // Record layout and constant values
    localparam int RECORD_BYTES = 10;
    localparam int BYTE_IDX_W   = 4;
    localparam logic [15:0] BASE_UNMAPPED   = 16'hFFFF;
    localparam logic [6:0]  DEAD_ZONE_RESET = 7'd32;
    localparam logic [7:0]  BIT_CONNECTED   = 8'h80;
    localparam logic [7:0]  BIT_SONY        = 8'h40;
    localparam logic [7:0]  BIT_L2          = 8'h01;
    localparam logic [7:0]  BIT_R2          = 8'h02;
    localparam logic [7:0]  TRIG_FULL       = 8'd255;
    localparam logic [4:0]  BTN_COUNT       = 5'd17;

    localparam logic [BYTE_IDX_W-1:0] REC_STATUS  = 4'd0;
    localparam logic [BYTE_IDX_W-1:0] REC_BTN_LOW = 4'd2;
    localparam logic [BYTE_IDX_W-1:0] REC_BTN_HI  = 4'd3;

    typedef logic [RECORD_BYTES-1:0][7:0] record_t;

    typedef enum logic [1:0] {
        CMD_REPORT  = 2'd0,
        CMD_BUTTON  = 2'd1,
        CMD_CONNECT = 2'd2
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Input tdata layout, lowest field declared last
    typedef struct packed {
        logic [3:0]        pad;
        logic [4:0]        button_id;
        logic              flag;
        logic [7:0]        rt;
        logic [7:0]        lt;
        logic signed [7:0] ry;
        logic signed [7:0] rx;
        logic signed [7:0] ly;
        logic signed [7:0] lx;
        logic [15:0]       buttons;
        logic [3:0]        dpad;
        logic [1:0]        player;
    } in_item_t;

    // Output tdata layout, lowest field declared last
    typedef struct packed {
        logic [5:0]        pad;
        logic [7:0]        out_rt;
        logic [7:0]        out_lt;
        logic signed [7:0] out_ry;
        logic signed [7:0] out_rx;
        logic signed [7:0] out_ly;
        logic signed [7:0] out_lx;
        logic [7:0]        buttons_high;
        logic [7:0]        buttons_low;
        logic [7:0]        sticks_byte;
        logic [7:0]        status_byte;
        logic [1:0]        out_player;
        logic [15:0]       record_addr;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic emit;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [BYTE_IDX_W-1:0] idx;
        logic [7:0]            mask;
    } btn_loc_t;

    // Record byte and bit for a mapped button id
    function automatic btn_loc_t btn_loc(input logic [4:0] bid);
        btn_loc_t loc;
        loc.idx  = REC_STATUS;
        loc.mask = 8'h00;
        case (bid)
            5'd0:  begin loc.idx = REC_STATUS;  loc.mask = 8'h01; end
            5'd1:  begin loc.idx = REC_STATUS;  loc.mask = 8'h02; end
            5'd2:  begin loc.idx = REC_STATUS;  loc.mask = 8'h04; end
            5'd3:  begin loc.idx = REC_STATUS;  loc.mask = 8'h08; end
            5'd4:  begin loc.idx = REC_BTN_LOW; loc.mask = 8'h01; end
            5'd5:  begin loc.idx = REC_BTN_LOW; loc.mask = 8'h02; end
            5'd6:  begin loc.idx = REC_BTN_LOW; loc.mask = 8'h08; end
            5'd7:  begin loc.idx = REC_BTN_LOW; loc.mask = 8'h10; end
            5'd8:  begin loc.idx = REC_BTN_LOW; loc.mask = 8'h40; end
            5'd9:  begin loc.idx = REC_BTN_LOW; loc.mask = 8'h80; end
            5'd10: begin loc.idx = REC_BTN_HI;  loc.mask = 8'h01; end
            5'd11: begin loc.idx = REC_BTN_HI;  loc.mask = 8'h02; end
            5'd12: begin loc.idx = REC_BTN_HI;  loc.mask = 8'h04; end
            5'd13: begin loc.idx = REC_BTN_HI;  loc.mask = 8'h08; end
            5'd14: begin loc.idx = REC_BTN_HI;  loc.mask = 8'h10; end
            5'd15: begin loc.idx = REC_BTN_HI;  loc.mask = 8'h20; end
            5'd16: begin loc.idx = REC_BTN_HI;  loc.mask = 8'h40; end
            default: begin loc.idx = REC_STATUS; loc.mask = 8'h00; end
        endcase
        return loc;
    endfunction

    // Encode one stick to a hat: deadzone, then 2:1 cardinal/diagonal split
    function automatic logic [3:0] stick_hat(input logic signed [7:0] x,
                                             input logic signed [7:0] y,
                                             input logic [6:0] dz);
        logic [7:0] ax;
        logic [7:0] ay;
        logic [3:0] v;
        logic [3:0] h;
        logic [3:0] hat;
        ax  = x[7] ? 8'(-x) : 8'(x);
        ay  = y[7] ? 8'(-y) : 8'(y);
        v   = y[7] ? 4'h1 : 4'h2;
        h   = x[7] ? 4'h4 : 4'h8;
        if (ax <= {1'b0, dz} && ay <= {1'b0, dz}) begin
            hat = 4'h0;
        end else if ({1'b0, ay} >= {ax, 1'b0}) begin
            hat = v;
        end else if ({1'b0, ax} >= {ay, 1'b0}) begin
            hat = h;
        end else begin
            hat = v | h;
        end
        return hat;
    endfunction

endpackage

// ===== hdl/gmr_ctrl.sv =====
// Controller of the gamepad record mapper: load an item, then commit it.
// Depends on gmr_pkg for the state, command and status types.
module gmr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gmr_pkg::dp_stat_t stat,
    output gmr_pkg::dp_cmd_t  cmd
);
    import gmr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold while a result must go out and the output is still full
                if (!stat.emit || stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/gmr_datapath.sv =====
// Datapath of the gamepad record mapper: config registers, record store,
// command decode and record update, output register. Depends on gmr_pkg.
module gmr_datapath #(
    parameter int NUM_PLAYERS = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [gmr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gmr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [gmr_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [gmr_pkg::IN_TUSER_W-1:0]   s_tuser,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [gmr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  gmr_pkg::dp_cmd_t                 cmd,
    output gmr_pkg::dp_stat_t                stat
);
    import gmr_pkg::*;

    localparam int PIDX_W  = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;
    localparam int PCMP_W  = ($clog2(NUM_PLAYERS + 1) > 3) ? $clog2(NUM_PLAYERS + 1) : 3;
    localparam int STORE_BYTES = NUM_PLAYERS * RECORD_BYTES;
    localparam logic [16:0] BASE_LIMIT = 17'(65536 - STORE_BYTES);

    logic [15:0]            record_base_reg;
    logic [6:0]             dead_zone_reg;
    in_item_t               in_reg;
    logic [IN_TUSER_W-1:0]  kind_reg;
    record_t                rec_mem [NUM_PLAYERS];
    record_t                rec_rd_reg;
    logic [NUM_PLAYERS-1:0] rec_valid_reg;
    out_item_t              out_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    in_item_t          s_item;
    logic [PIDX_W-1:0] s_pidx;
    logic [PIDX_W-1:0] pidx;
    logic              player_ok;
    logic              touch;
    logic              emit;
    record_t           rec_old;
    record_t           rec_new;
    btn_loc_t          loc;
    logic [7:0]        b1;
    logic [7:0]        lt_c;
    logic [7:0]        rt_c;
    logic [15:0]       record_addr;

    // Configuration writes; reject bases whose records would wrap past the top
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_base_reg <= BASE_UNMAPPED;
            dead_zone_reg   <= DEAD_ZONE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RECORD_BASE: begin
                    if (cfg_wdata == BASE_UNMAPPED || {1'b0, cfg_wdata} <= BASE_LIMIT) begin
                        record_base_reg <= cfg_wdata;
                    end
                end
                REG_DEAD_ZONE: begin
                    dead_zone_reg <= cfg_wdata[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_item = in_item_t'(s_tdata);
    assign s_pidx = PIDX_W'(s_item.player);

    // Capture the accepted item and read its player's record
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg     <= s_item;
            kind_reg   <= s_tuser;
            rec_rd_reg <= rec_mem[s_pidx];
        end
    end

    // Decode the held item
    assign pidx      = PIDX_W'(in_reg.player);
    assign player_ok = PCMP_W'(in_reg.player) < PCMP_W'(NUM_PLAYERS);
    assign rec_old   = (player_ok && rec_valid_reg[pidx]) ? rec_rd_reg : '0;
    assign loc       = btn_loc(in_reg.button_id);

    // Trigger coupling with the L2/R2 bits
    always_comb begin
        b1   = in_reg.buttons[15:8];
        lt_c = (b1[0] && in_reg.lt == 8'd0) ? TRIG_FULL : in_reg.lt;
        rt_c = (b1[1] && in_reg.rt == 8'd0) ? TRIG_FULL : in_reg.rt;
        if (lt_c > {1'b0, dead_zone_reg}) begin
            b1 = b1 | BIT_L2;
        end
        if (rt_c > {1'b0, dead_zone_reg}) begin
            b1 = b1 | BIT_R2;
        end
    end

    // Build the updated record
    always_comb begin
        rec_new = rec_old;
        touch   = 1'b0;
        case (kind_reg)
            CMD_REPORT: begin
                touch      = player_ok;
                rec_new[0] = 8'(in_reg.dpad) | BIT_CONNECTED
                             | (in_reg.flag ? BIT_SONY : 8'h00);
                rec_new[1] = {stick_hat(in_reg.rx, in_reg.ry, dead_zone_reg),
                              stick_hat(in_reg.lx, in_reg.ly, dead_zone_reg)};
                rec_new[2] = in_reg.buttons[7:0];
                rec_new[3] = b1;
                rec_new[4] = in_reg.lx;
                rec_new[5] = in_reg.ly;
                rec_new[6] = in_reg.rx;
                rec_new[7] = in_reg.ry;
                rec_new[8] = lt_c;
                rec_new[9] = rt_c;
            end
            CMD_BUTTON: begin
                touch = player_ok && (in_reg.button_id < BTN_COUNT);
                if (in_reg.flag) begin
                    rec_new[loc.idx] = rec_old[loc.idx] | loc.mask;
                end else begin
                    rec_new[loc.idx] = rec_old[loc.idx] & ~loc.mask;
                end
            end
            CMD_CONNECT: begin
                touch = player_ok;
                if (in_reg.flag) begin
                    rec_new[0] = rec_old[0] | BIT_CONNECTED;
                end else begin
                    rec_new = '0;
                end
            end
            default: begin
                touch = 1'b0;
            end
        endcase
    end

    assign emit        = touch && (record_base_reg != BASE_UNMAPPED);
    assign record_addr = record_base_reg + 16'(16'(in_reg.player) * 16'(RECORD_BYTES));

    // Write back the record on commit
    always_ff @(posedge aclk) begin
        if (cmd.commit && touch) begin
            rec_mem[pidx] <= rec_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_valid_reg <= '0;
        end else if (cmd.commit && touch) begin
            rec_valid_reg[pidx] <= 1'b1;
        end
    end

    // Output register: load on commit, drop when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && emit) begin
            out_reg.pad          <= '0;
            out_reg.record_addr  <= record_addr;
            out_reg.out_player   <= in_reg.player;
            out_reg.status_byte  <= rec_new[0];
            out_reg.sticks_byte  <= rec_new[1];
            out_reg.buttons_low  <= rec_new[2];
            out_reg.buttons_high <= rec_new[3];
            out_reg.out_lx       <= rec_new[4];
            out_reg.out_ly       <= rec_new[5];
            out_reg.out_rx       <= rec_new[6];
            out_reg.out_ry       <= rec_new[7];
            out_reg.out_lt       <= rec_new[8];
            out_reg.out_rt       <= rec_new[9];
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = OUT_TDATA_W'(out_reg);
    assign stat.emit     = emit;
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule

// ===== hdl/gamepad_record_mapper.sv =====
// Flow: an accepted item is held in the input register; from the EXEC state the controller commits it,
// which updates its record and loads any result into the output register. No new item is taken
// until the held one is committed, and the commit waits while the output stalls.
// Reset: synchronous, active low; every record reads as zero (disconnected),
// the base is unmapped and the dead zone is 32, at once with no clearing pass.
module gamepad_record_mapper #(
    parameter int NUM_PLAYERS = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [gmr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gmr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // command items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // player, dpad, buttons, lx, ly, rx, ry, lt, rt, flag, button_id, zero pad
    input  logic [gmr_pkg::IN_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic [gmr_pkg::IN_TUSER_W-1:0]   s_tuser,
    // record items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // record_addr, out_player, status_byte, sticks_byte, buttons_low,
    // buttons_high, out_lx, out_ly, out_rx, out_ry, out_lt, out_rt, zero pad
    output logic [gmr_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import gmr_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    gmr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    gmr_datapath #(
        .NUM_PLAYERS (NUM_PLAYERS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

endmodule

// ===== hdl/gmr_checker.sv =====
// Port-level checks of the gamepad record mapper, bound to the top level.
// Depends on gmr_pkg and gamepad_record_mapper_macros.svh.
`include "gamepad_record_mapper_macros.svh"

module gmr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gmr_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import gmr_pkg::*;

    // A stalled result stays offered and unchanged
    `GMR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `GMR_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")

    // One item at a time: the block is busy right after an accept
    `GMR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted back to back")

    // A new result only follows a cycle spent on an item
    `GMR_ASSERT_SAME(a_result_from_item, $rose(m_tvalid), $past(!s_tready), "result without an item")

endmodule

bind gamepad_record_mapper gmr_checker u_gmr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
